@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the frame slicer.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/mrfs_pkg.sv @@
// Shared types and constants of the frame slicer: commands, register indexes,
// sizes of the frame store and the controller/datapath interface structs.
package mrfs_pkg;

  localparam int MAX_FRAME_BYTES = 256;
  localparam int LANES           = 8;
  localparam int LANE_W          = $clog2(LANES);
  localparam int ROWS            = MAX_FRAME_BYTES / LANES;
  localparam int ROW_W           = $clog2(ROWS);
  localparam int FILL_W          = $clog2(MAX_FRAME_BYTES + 1);
  localparam int COUNT_W         = $clog2(LANES + 1);

  localparam int CMD_W     = 2;
  localparam int BYTE_W    = 8;
  localparam int TIME_W    = 32;
  localparam int CHUNK_W   = LANES * BYTE_W;
  localparam int S_DATA_W  = 40;   // data_byte, time_us
  localparam int M_DATA_W  = 112;  // start_time_us, frame_length, chunk_data, chunk_count
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [TIME_W-1:0] GAP_LIMIT_RESET = 32'd4808;

  localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MARK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIVER   = 1'd1;

  localparam logic KIND_CHUNK    = 1'b0;
  localparam logic KIND_OVERFLOW = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // input request taken this cycle
    logic rd_en;   // read the current store row
    logic load;    // move the read row into the output register
    logic finish;  // last chunk loaded, release the frame
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic readout_hit;  // pending input is a check that ends a delivered frame
    logic out_free;     // output register can take a new result
    logic last_row;     // current row is the final chunk of the frame
  } dp_status_t;

endpackage

@@ rtl/mrfs_ctrl.sv @@
// Controller of the frame slicer: accepts requests and sequences the chunk
// readout of a finished frame. Depends on mrfs_pkg.
module mrfs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  mrfs_pkg::dp_status_t  status,
  output mrfs_pkg::dp_cmd_t     cmd
);

  mrfs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrfs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mrfs_pkg::ST_IDLE: begin
        if (s_tvalid && s_tready && status.readout_hit) begin
          state_next = mrfs_pkg::ST_READ;
        end
      end
      mrfs_pkg::ST_READ: begin
        state_next = mrfs_pkg::ST_EMIT;
      end
      mrfs_pkg::ST_EMIT: begin
        if (status.out_free) begin
          state_next = status.last_row ? mrfs_pkg::ST_IDLE : mrfs_pkg::ST_READ;
        end
      end
      default: begin
        state_next = mrfs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      mrfs_pkg::ST_IDLE: begin
        s_tready   = status.out_free;
        cmd.accept = s_tvalid && status.out_free;
      end
      mrfs_pkg::ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      mrfs_pkg::ST_EMIT: begin
        cmd.load   = status.out_free;
        cmd.finish = status.out_free && status.last_row;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/mrfs_dp.sv @@
// Datapath of the frame slicer: configuration registers, frame state, the
// row-organized frame store and the output register. Depends on mrfs_pkg.
module mrfs_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [mrfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mrfs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [mrfs_pkg::S_DATA_W-1:0]       s_tdata,
  input  logic [mrfs_pkg::CMD_W-1:0]          s_tuser,
  input  logic                                m_tready,
  output logic                                m_tvalid,
  output logic [mrfs_pkg::M_DATA_W-1:0]       m_tdata,
  output logic                                m_tuser,
  output logic                                m_tlast,
  input  mrfs_pkg::dp_cmd_t                   cmd,
  output mrfs_pkg::dp_status_t                status
);

  logic [mrfs_pkg::TIME_W-1:0]  gap_limit;
  logic                         deliver_en;
  logic                         frame_held;
  logic [mrfs_pkg::FILL_W-1:0]  fill_count;
  logic [mrfs_pkg::TIME_W-1:0]  start_time;
  logic [mrfs_pkg::TIME_W-1:0]  last_time;
  logic [mrfs_pkg::ROW_W-1:0]   row_idx;
  logic [mrfs_pkg::CHUNK_W-1:0] rd_data;

  logic [mrfs_pkg::CHUNK_W-1:0] mem [mrfs_pkg::ROWS];

  logic                         out_valid;
  logic                         out_kind;
  logic [mrfs_pkg::TIME_W-1:0]  out_start;
  logic [mrfs_pkg::FILL_W-1:0]  out_len;
  logic [mrfs_pkg::CHUNK_W-1:0] out_data;
  logic [mrfs_pkg::COUNT_W-1:0] out_count;
  logic                         out_last;

  logic [mrfs_pkg::BYTE_W-1:0]  in_byte;
  logic [mrfs_pkg::TIME_W-1:0]  in_time;
  logic [mrfs_pkg::FILL_W-1:0]  eff_fill;
  logic                         overflow;
  logic                         is_byte, is_mark, is_check;
  logic [mrfs_pkg::TIME_W-1:0]  delta;
  logic                         gap_hit;
  logic [mrfs_pkg::FILL_W-1:0]  fill_m1;
  logic [mrfs_pkg::ROW_W-1:0]   last_row_idx;
  logic [mrfs_pkg::COUNT_W-1:0] chunk_count;
  logic [mrfs_pkg::CHUNK_W-1:0] chunk_data;
  logic                         out_free;

  assign in_byte  = s_tdata[mrfs_pkg::BYTE_W-1:0];
  assign in_time  = s_tdata[mrfs_pkg::BYTE_W +: mrfs_pkg::TIME_W];
  assign is_byte  = s_tuser == mrfs_pkg::CMD_BYTE;
  assign is_mark  = s_tuser == mrfs_pkg::CMD_MARK;
  assign is_check = s_tuser == mrfs_pkg::CMD_CHECK;

  // A byte with no frame held starts one at fill zero
  assign eff_fill = frame_held ? fill_count : '0;
  assign overflow = eff_fill == mrfs_pkg::FILL_W'(mrfs_pkg::MAX_FRAME_BYTES);

  assign delta   = in_time - last_time;
  assign gap_hit = frame_held && (fill_count != '0) && (delta > gap_limit);

  assign fill_m1      = fill_count - mrfs_pkg::FILL_W'(1);
  assign last_row_idx = fill_m1[mrfs_pkg::LANE_W +: mrfs_pkg::ROW_W];

  assign out_free = !out_valid || m_tready;

  assign status.readout_hit = is_check && gap_hit && deliver_en;
  assign status.out_free    = out_free;
  assign status.last_row    = row_idx == last_row_idx;

  always_comb begin
    if (status.last_row) begin
      chunk_count = mrfs_pkg::COUNT_W'(fill_m1[mrfs_pkg::LANE_W-1:0])
                    + mrfs_pkg::COUNT_W'(1);
    end else begin
      chunk_count = mrfs_pkg::COUNT_W'(mrfs_pkg::LANES);
    end
    // zero the bytes past the end of the frame
    for (int b = 0; b < mrfs_pkg::LANES; b++) begin
      if (mrfs_pkg::COUNT_W'(b) < chunk_count) begin
        chunk_data[b*mrfs_pkg::BYTE_W +: mrfs_pkg::BYTE_W] =
          rd_data[b*mrfs_pkg::BYTE_W +: mrfs_pkg::BYTE_W];
      end else begin
        chunk_data[b*mrfs_pkg::BYTE_W +: mrfs_pkg::BYTE_W] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit  <= mrfs_pkg::GAP_LIMIT_RESET;
      deliver_en <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_index == mrfs_pkg::REG_GAP_LIMIT) begin
        gap_limit <= cfg_data;
      end else if (cfg_index == mrfs_pkg::REG_DELIVER) begin
        deliver_en <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_held <= 1'b0;
      fill_count <= '0;
      start_time <= '0;
      last_time  <= '0;
    end else if (cmd.accept) begin
      if (is_byte) begin
        if (!frame_held) begin
          frame_held <= 1'b1;
          start_time <= in_time;
        end
        fill_count <= overflow ? '0 : eff_fill + mrfs_pkg::FILL_W'(1);
        last_time  <= in_time;
      end else if (is_mark) begin
        last_time <= in_time;
      end else if (is_check && gap_hit && !deliver_en) begin
        // drop the frame, keep it open
        fill_count <= '0;
      end
    end else if (cmd.finish) begin
      frame_held <= 1'b0;
      fill_count <= '0;
    end
  end

  // Frame store: one byte lane written per request, one row read per chunk
  always_ff @(posedge clk) begin
    if (cmd.accept && is_byte && !overflow) begin
      mem[eff_fill[mrfs_pkg::LANE_W +: mrfs_pkg::ROW_W]]
         [eff_fill[mrfs_pkg::LANE_W-1:0]*mrfs_pkg::BYTE_W +: mrfs_pkg::BYTE_W] <= in_byte;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[row_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      row_idx <= '0;
    end else if (cmd.load && !status.last_row) begin
      row_idx <= row_idx + mrfs_pkg::ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.accept && is_byte && overflow && deliver_en) || cmd.load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_kind  <= mrfs_pkg::KIND_CHUNK;
      out_start <= start_time;
      out_len   <= fill_count;
      out_data  <= chunk_data;
      out_count <= chunk_count;
      out_last  <= status.last_row;
    end else if (cmd.accept && is_byte && overflow && deliver_en) begin
      out_kind  <= mrfs_pkg::KIND_OVERFLOW;
      out_start <= start_time;
      out_len   <= '0;
      out_data  <= '0;
      out_count <= '0;
      out_last  <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {3'b000, out_count, out_data, out_len, out_start};

endmodule

@@ rtl/modbus_rtu_frame_slicer.sv @@
// Modbus RTU frame slicer: collects received bytes, detects the inter-frame
// gap and delivers frames as 8-byte chunks.
//
// Input stream: s_tuser is the request kind (byte, time mark, gap check);
// s_tdata carries the byte and the microsecond time stamp. Output stream:
// m_tuser is the result kind (chunk or overflow error), m_tlast marks the
// final result of a request. Config: cfg_index 0 is the gap limit in
// microseconds, 1 is the delivery enable; cfg_ready is always high.
// An overflow error is in the output register the cycle after its byte is
// taken. A gap check that ends a delivered frame reads one store row per
// chunk: each chunk passes the READ state, a registered read of the frame
// store, and then the EMIT state, which loads it into the output register
// once that is free. A frame gives at most 32 chunks.
// s_tready is low during that readout.
// Reset empties the frame and restores gap limit 4808 and delivery on; the
// store itself needs no clearing. While the receiver holds m_tready low a
// pending result stays in the output register and no new request or chunk is taken.
module modbus_rtu_frame_slicer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mrfs_pkg::S_DATA_W-1:0]   s_tdata,   // data_byte[7:0], time_us[39:8]
  input  logic [mrfs_pkg::CMD_W-1:0]      s_tuser,   // cmd[1:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mrfs_pkg::M_DATA_W-1:0]   m_tdata,   // start_time_us[31:0], frame_length[40:32],
                                                     // chunk_data[104:41], chunk_count[108:105]
  output logic                            m_tuser,   // kind[0]
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mrfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrfs_pkg::CFG_DATA_W-1:0] cfg_data
);

  mrfs_pkg::dp_cmd_t    dp_cmd;
  mrfs_pkg::dp_status_t dp_status;

  assign cfg_ready = 1'b1;

  mrfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (dp_status),
    .cmd      (dp_cmd)
  );

  mrfs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (dp_cmd),
    .status    (dp_status)
  );

`include "assert_macros.svh"

  `ASSERT_NEXT(a_read_spacing, dp_cmd.rd_en, !dp_cmd.rd_en && !s_tready, "store read repeated back to back")
  `ASSERT_ALWAYS(a_finish_slot, !dp_cmd.finish || !m_tvalid || m_tready, "chunk loaded over a pending result")
  `ASSERT_ALWAYS(a_no_accept_in_readout, !(dp_cmd.accept && (dp_cmd.rd_en || dp_cmd.load)), "request taken during readout")
  `ASSERT_NEXT(a_finish_last, dp_cmd.finish, m_tvalid && m_tlast, "final chunk not marked last")

endmodule
